/* sv/nfha_pkg.sv */
// nfha_pkg: types, codes and constants shared by the next-fit heap allocator
// used by nfha_store and next_fit_heap_allocator_unit
package nfha_pkg;

	localparam int XW = 36;
	localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
	localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
	localparam logic [31:0] PROLOGUE_TAG = 32'h0000_0009;
	localparam logic [31:0] INIT_CHUNK = 32'h0001_0000;
	localparam logic [XW-1:0] FIRST_BLOCK = XW'(8);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic [XW-1:0] rd_addr;
		logic wr_en;
		logic [XW-1:0] wr_addr;
		logic [31:0] wr_data;
	} mem_req_t;

	function automatic logic [XW-1:0] size_x(input logic [31:0] w);
		return {{(XW-32){1'b0}}, w & SIZE_MASK};
	endfunction

endpackage

/* sv/nfha_store.sv */
// nfha_store: heap word memory with bounds check against the break and a
// post-reset initialization sweep; depends on nfha_pkg
module nfha_store import nfha_pkg::*; #(
	parameter int HEAP_WORDS = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic [XW-1:0] heap_end,
	input mem_req_t req,
	output logic [31:0] rd_data,
	output logic busy
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam logic BIG = (64'(HEAP_WORDS) * 64'd4) >= (64'd16 + 64'(INIT_CHUNK));
	localparam logic [AW:0] DEPTH = (AW+1)'(HEAP_WORDS);
	localparam logic [AW:0] FTR_IDX = (AW+1)'((16 + INIT_CHUNK - 8) / 4);
	localparam logic [AW:0] EPI_IDX = (AW+1)'((16 + INIT_CHUNK - 4) / 4);

	logic [31:0] mem [HEAP_WORDS];
	logic [AW:0] clr_q;
	logic [31:0] rd_mem_q;
	logic oor_q;
	logic [31:0] init_val;
	logic wr_ok, rd_ok, wen;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	assign busy = clr_q < DEPTH;
	assign wr_ok = !req.wr_addr[XW-1] && (req.wr_addr < heap_end);
	assign rd_ok = !req.rd_addr[XW-1] && (req.rd_addr < heap_end);

	always_comb begin
		init_val = '0;
		if (clr_q == (AW+1)'(1) || clr_q == (AW+1)'(2)) begin
			init_val = PROLOGUE_TAG;
		end else if (clr_q == (AW+1)'(3)) begin
			init_val = BIG ? INIT_CHUNK : ALLOC_BIT;
		end else if (BIG && clr_q == FTR_IDX) begin
			init_val = INIT_CHUNK;
		end else if (BIG && clr_q == EPI_IDX) begin
			init_val = ALLOC_BIT;
		end
	end

	assign wen = busy || (req.wr_en && wr_ok);
	assign waddr = busy ? clr_q[AW-1:0] : req.wr_addr[AW+1:2];
	assign wdata = busy ? init_val : req.wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_mem_q <= mem[req.rd_addr[AW+1:2]];
			oor_q <= !rd_ok;
		end
	end

	assign rd_data = oor_q ? ALLOC_BIT : rd_mem_q;

endmodule

/* sv/next_fit_heap_allocator_unit.sv */
// next_fit_heap_allocator_unit: boundary-tag heap allocator, next-fit search
// with immediate coalescing; depends on nfha_pkg and nfha_store
// an allocation searches from the next-fit rover, walking one block at a time, and grows the
// heap at the epilogue; a free writes its tags and then coalesces; a zero size goes straight
// to S_FIN; out of memory follows the walk; a result not yet taken holds S_FIN
// throughput: one transaction at a time; reset: memory swept word by word, in_ready low
module next_fit_heap_allocator_unit import nfha_pkg::*; #(
	parameter int HEAP_WORDS = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [18:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [18:0] request_bytes,
	input logic [17:0] block_addr,
	output logic out_valid,
	input logic out_ready,
	output logic [17:0] result_addr,
	output logic [1:0] status
);

	localparam logic [XW-1:0] HEAP_BYTES = XW'(64'(HEAP_WORDS) * 64'd4);
	localparam logic [XW-1:0] INIT_END =
		(XW'(16) + XW'(INIT_CHUNK) <= HEAP_BYTES) ? XW'(16) + XW'(INIT_CHUNK) : XW'(16);

	typedef enum logic [5:0] {
		S_IDLE, S_SRCH0, S_SRCH, S_GROW1, S_GROW2, S_GROW3,
		S_F0, S_F1, S_F2, S_F3,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
		S_MA1, S_MA2, S_MB1, S_MB2, S_MB3, S_MB4,
		S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_RET,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_N0, S_N1, S_FIN
	} state_t;

	state_t state_q;
	logic [XW-1:0] heap_end_q, next_fit_q, bp_q, p_q, t_q;
	logic [18:0] chunk_q;
	logic [19:0] asz_q;
	logic [31:0] sz_q, hs_q, vp_q, csz_q;
	logic pa_q, grow_q;
	logic [1:0] st_q;
	logic out_valid_q;
	logic [17:0] result_q;
	logic [1:0] status_q;

	mem_req_t req;
	logic [31:0] rd_data;
	logic busy;

	logic [XW-1:0] rsz;
	logic [31:0] rmask, asz32, alloc_tag, rem32;
	logic fit, split;
	logic [19:0] r15, ext_c;
	logic [17:0] words_c;
	logic [18:0] wrd_c;
	logic [20:0] gsz;
	logic [XW-1:0] grow_end;

	nfha_store #(.HEAP_WORDS(HEAP_WORDS)) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.heap_end(heap_end_q),
		.req(req),
		.rd_data(rd_data),
		.busy(busy)
	);

	assign rmask = rd_data & SIZE_MASK;
	assign rsz = size_x(rd_data);
	assign asz32 = {12'b0, asz_q};
	assign alloc_tag = asz32 | ALLOC_BIT;
	assign rem32 = rmask - asz32;
	assign fit = !rd_data[0] && (asz32 <= rmask);
	assign split = rem32 >= 32'd16;
	assign r15 = {1'b0, request_bytes} + 20'd15;
	assign ext_c = (asz_q > {1'b0, chunk_q}) ? asz_q : {1'b0, chunk_q};
	assign words_c = ext_c[19:2];
	assign wrd_c = {1'b0, words_c} + 19'(words_c[0]);
	assign gsz = {wrd_c, 2'b00};
	assign grow_end = heap_end_q + XW'(gsz);

	assign in_ready = (state_q == S_IDLE) && !busy;
	assign out_valid = out_valid_q;
	assign result_addr = result_q;
	assign status = status_q;

	always_comb begin
		req = '0;
		unique case (state_q)
			S_SRCH0, S_F0, S_F2, S_M3, S_MA1, S_MC3, S_P0, S_P2, S_P4, S_P8, S_N0: begin
				req.rd_en = 1'b1;
				req.rd_addr = bp_q - XW'(4);
			end
			S_M0, S_MB1, S_MB3, S_MC1: begin
				req.rd_en = 1'b1;
				req.rd_addr = bp_q - XW'(8);
			end
			S_SRCH: begin
				req.rd_en = (rmask != '0) && !fit;
				req.rd_addr = bp_q + rsz - XW'(4);
			end
			S_GROW1: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q - XW'(4);
				req.wr_data = sz_q;
			end
			S_GROW2: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + XW'(sz_q) - XW'(8);
				req.wr_data = sz_q;
			end
			S_GROW3: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + XW'(sz_q) - XW'(4);
				req.wr_data = ALLOC_BIT;
			end
			S_F1: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q - XW'(4);
				req.wr_data = rmask;
			end
			S_F3, S_MA2: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + rsz - XW'(8);
				req.wr_data = sz_q;
			end
			S_M1: begin
				req.rd_en = 1'b1;
				req.rd_addr = bp_q - rsz - XW'(4);
			end
			S_M2: begin
				req.rd_en = 1'b1;
				req.rd_addr = p_q + rsz - XW'(8);
			end
			S_M4, S_MC4: begin
				req.rd_en = 1'b1;
				req.rd_addr = bp_q + rsz - XW'(4);
			end
			S_M5: begin
				if (pa_q && !rd_data[0]) begin
					req.wr_en = 1'b1;
					req.wr_addr = bp_q - XW'(4);
					req.wr_data = hs_q + rmask;
				end else if (!pa_q && rd_data[0]) begin
					req.wr_en = 1'b1;
					req.wr_addr = bp_q + XW'(hs_q) - XW'(8);
					req.wr_data = hs_q + vp_q;
				end else if (!pa_q) begin
					req.rd_en = 1'b1;
					req.rd_addr = bp_q + XW'(hs_q) + rsz - XW'(8);
				end
			end
			S_MB2, S_MC2: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q - rsz - XW'(4);
				req.wr_data = sz_q;
			end
			S_MC5: begin
				req.wr_en = 1'b1;
				req.wr_addr = t_q + rsz - XW'(8);
				req.wr_data = sz_q;
			end
			S_P1: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q - XW'(4);
				req.wr_data = split ? alloc_tag : (rmask | ALLOC_BIT);
			end
			S_P3: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + rsz - XW'(8);
				req.wr_data = alloc_tag;
			end
			S_P5: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + rsz - XW'(4);
				req.wr_data = csz_q - asz32;
			end
			S_P6: begin
				req.rd_en = 1'b1;
				req.rd_addr = t_q - XW'(4);
			end
			S_P7: begin
				req.wr_en = 1'b1;
				req.wr_addr = t_q + rsz - XW'(8);
				req.wr_data = csz_q - asz32;
			end
			S_P9: begin
				req.wr_en = 1'b1;
				req.wr_addr = bp_q + rsz - XW'(8);
				req.wr_data = csz_q | ALLOC_BIT;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_end_q <= INIT_END;
			next_fit_q <= FIRST_BLOCK;
			chunk_q <= 19'(INIT_CHUNK);
			out_valid_q <= 1'b0;
			result_q <= '0;
			status_q <= ST_OK;
			bp_q <= '0;
			p_q <= '0;
			t_q <= '0;
			asz_q <= '0;
			sz_q <= '0;
			hs_q <= '0;
			vp_q <= '0;
			csz_q <= '0;
			pa_q <= 1'b0;
			grow_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (opcode == OP_FREE) begin
							st_q <= ST_OK;
							bp_q <= {{(XW-18){1'b0}}, block_addr};
							grow_q <= 1'b0;
							state_q <= S_F0;
						end else if (request_bytes == '0) begin
							st_q <= ST_ZERO;
							bp_q <= '0;
							state_q <= S_FIN;
						end else begin
							st_q <= ST_OK;
							asz_q <= (request_bytes <= 19'd8) ? 20'd16 : (r15 & ~20'd7);
							bp_q <= next_fit_q;
							state_q <= S_SRCH0;
						end
					end
				end
				S_SRCH0: state_q <= S_SRCH;
				S_SRCH: begin
					if (rmask == '0) begin
						next_fit_q <= FIRST_BLOCK;
						if (grow_end > HEAP_BYTES) begin
							st_q <= ST_OOM;
							bp_q <= '0;
							state_q <= S_FIN;
						end else begin
							heap_end_q <= grow_end;
							bp_q <= heap_end_q;
							sz_q <= 32'(gsz);
							grow_q <= 1'b1;
							state_q <= S_GROW1;
						end
					end else if (fit) begin
						state_q <= S_P0;
					end else begin
						bp_q <= bp_q + rsz;
					end
				end
				S_GROW1: state_q <= S_GROW2;
				S_GROW2: state_q <= S_GROW3;
				S_GROW3: state_q <= S_M0;
				S_F0: state_q <= S_F1;
				S_F1: begin
					sz_q <= rmask;
					state_q <= S_F2;
				end
				S_F2: state_q <= S_F3;
				S_F3: state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: begin
					p_q <= bp_q - rsz;
					state_q <= S_M2;
				end
				S_M2: begin
					vp_q <= rmask;
					state_q <= S_M3;
				end
				S_M3: begin
					pa_q <= rd_data[0];
					state_q <= S_M4;
				end
				S_M4: begin
					hs_q <= rmask;
					state_q <= S_M5;
				end
				S_M5: begin
					if (pa_q && rd_data[0]) begin
						state_q <= S_RET;
					end else if (pa_q) begin
						sz_q <= hs_q + rmask;
						state_q <= S_MA1;
					end else if (rd_data[0]) begin
						sz_q <= hs_q + vp_q;
						state_q <= S_MB1;
					end else begin
						sz_q <= hs_q + vp_q;
						state_q <= S_MC1;
					end
				end
				S_MA1: state_q <= S_MA2;
				S_MA2: begin
					next_fit_q <= bp_q;
					state_q <= S_RET;
				end
				S_MB1: state_q <= S_MB2;
				S_MB2: state_q <= S_MB3;
				S_MB3: state_q <= S_MB4;
				S_MB4: begin
					bp_q <= bp_q - rsz;
					next_fit_q <= bp_q - rsz;
					state_q <= S_RET;
				end
				S_MC1: begin
					sz_q <= sz_q + rmask;
					state_q <= S_MC2;
				end
				S_MC2: state_q <= S_MC3;
				S_MC3: state_q <= S_MC4;
				S_MC4: begin
					t_q <= bp_q + rsz;
					state_q <= S_MC5;
				end
				S_MC5: state_q <= S_MB3;
				S_RET: state_q <= grow_q ? S_P0 : S_FIN;
				S_P0: state_q <= S_P1;
				S_P1: begin
					csz_q <= rmask;
					state_q <= split ? S_P2 : S_P8;
				end
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: begin
					t_q <= bp_q + rsz;
					state_q <= S_P6;
				end
				S_P6: state_q <= S_P7;
				S_P7: state_q <= S_N0;
				S_P8: state_q <= S_P9;
				S_P9: state_q <= S_N0;
				S_N0: state_q <= S_N1;
				S_N1: begin
					next_fit_q <= bp_q + rsz;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						result_q <= bp_q[17:0];
						status_q <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for next_fit_heap_allocator_unit, carrying its own
// word-level heap predictor; depends on nfha_pkg and the allocator RTL
// directed table first, then random allocate/free traffic over several chunk settings
module tb_top import nfha_pkg::*; ();

	localparam int NWORDS = 65536;
	localparam longint unsigned LIMIT = 64'd200_000_000;

	typedef struct {
		logic [17:0] addr;
		logic [1:0] st;
	} res_t;

	typedef struct {
		logic op;
		logic [18:0] req;
		logic [17:0] addr;
		bit typed;
		logic [17:0] e_addr;
		logic [1:0] e_st;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [18:0] cfg_wdata;
	logic in_valid, in_ready;
	logic opcode;
	logic [18:0] request_bytes;
	logic [17:0] block_addr;
	logic out_valid, out_ready;
	logic [17:0] result_addr;
	logic [1:0] status;

	next_fit_heap_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .request_bytes(request_bytes), .block_addr(block_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_addr(result_addr), .status(status)
	);

	// heap image and allocator state
	logic [31:0] hm [0:NWORDS-1];
	longint unsigned brk, rover, base_blk;
	logic [18:0] chunk;

	res_t pending [$];
	logic [17:0] live [$];
	int errors = 0;
	int snd_idle = 0, rcv_idle = 0;
	longint unsigned cycles = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("next_fit_heap_allocator_unit test failed");
			$finish;
		end
	end

	function automatic logic [31:0] heap_rd(longint unsigned a);
		if (a >= brk || (a >> 2) >= NWORDS)
			return 32'd1;
		return hm[a >> 2];
	endfunction

	function automatic void heap_wr(longint unsigned a, logic [31:0] v);
		if (a >= brk || (a >> 2) >= NWORDS)
			return;
		hm[a >> 2] = v;
	endfunction

	function automatic longint unsigned blk_size(longint unsigned bp);
		return heap_rd(bp - 4) & SIZE_MASK;
	endfunction

	function automatic longint unsigned blk_ftr(longint unsigned bp);
		return bp + blk_size(bp) - 8;
	endfunction

	function automatic longint unsigned blk_next(longint unsigned bp);
		return bp + blk_size(bp);
	endfunction

	function automatic longint unsigned blk_prev(longint unsigned bp);
		return bp - (heap_rd(bp - 8) & SIZE_MASK);
	endfunction

	function automatic longint unsigned coalesce(longint unsigned bp);
		logic pa, na;
		logic [31:0] sz, tp, tn;
		tp = heap_rd(blk_ftr(blk_prev(bp)));
		tn = heap_rd(blk_next(bp) - 4);
		pa = tp[0];
		na = tn[0];
		sz = 32'(blk_size(bp));
		if (pa && na)
			return bp;
		if (pa) begin
			sz += 32'(blk_size(blk_next(bp)));
			heap_wr(bp - 4, sz);
			heap_wr(blk_ftr(bp), sz);
		end else if (na) begin
			sz += 32'(blk_size(blk_prev(bp)));
			heap_wr(blk_ftr(bp), sz);
			heap_wr(blk_prev(bp) - 4, sz);
			bp = blk_prev(bp);
		end else begin
			sz += 32'(blk_size(blk_prev(bp))) + (heap_rd(blk_ftr(blk_next(bp))) & SIZE_MASK);
			heap_wr(blk_prev(bp) - 4, sz);
			heap_wr(blk_ftr(blk_next(bp)), sz);
			bp = blk_prev(bp);
		end
		rover = bp;
		return bp;
	endfunction

	function automatic bit grow_heap(longint unsigned words, output longint unsigned bpo);
		longint unsigned sz, bp;
		sz = words[0] ? (words + 1) * 4 : words * 4;
		bp = brk;
		bpo = 0;
		if (bp + sz > NWORDS * 4)
			return 1'b0;
		brk = bp + sz;
		heap_wr(bp - 4, 32'(sz));
		heap_wr(blk_ftr(bp), 32'(sz));
		heap_wr(blk_next(bp) - 4, 32'd1);
		bpo = coalesce(bp);
		return 1'b1;
	endfunction

	function automatic void place_block(longint unsigned bp, logic [31:0] asz);
		logic [31:0] csz;
		csz = 32'(blk_size(bp));
		if (csz - asz >= 32'd16) begin
			heap_wr(bp - 4, asz | ALLOC_BIT);
			heap_wr(blk_ftr(bp), asz | ALLOC_BIT);
			bp = blk_next(bp);
			heap_wr(bp - 4, csz - asz);
			heap_wr(blk_ftr(bp), csz - asz);
		end else begin
			heap_wr(bp - 4, csz | ALLOC_BIT);
			heap_wr(blk_ftr(bp), csz | ALLOC_BIT);
		end
	endfunction

	function automatic void heap_init();
		longint unsigned bp;
		foreach (hm[i])
			hm[i] = 32'd0;
		chunk = 19'd65536;
		brk = 16;
		hm[1] = PROLOGUE_TAG;
		hm[2] = PROLOGUE_TAG;
		hm[3] = 32'd1;
		base_blk = 8;
		rover = 8;
		void'(grow_heap(INIT_CHUNK / 4, bp));
	endfunction

	function automatic res_t predict_op(logic op, logic [18:0] req, logic [17:0] addr);
		res_t r;
		logic [31:0] asz, h, s;
		longint unsigned bp, ext, m;
		bit found;
		r.addr = '0;
		r.st = ST_OK;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				r.st = ST_ZERO;
			end else begin
				asz = (req <= 8) ? 32'd16 : 32'(8 * ((longint'(req) + 15) / 8));
				bp = rover;
				found = 1'b0;
				forever begin
					h = heap_rd(bp - 4);
					s = h & SIZE_MASK;
					if (s == 0)
						break;
					if (!h[0] && asz <= s) begin
						found = 1'b1;
						break;
					end
					bp += s;
				end
				if (!found) begin
					ext = (asz > chunk) ? asz : chunk;
					rover = base_blk;
					if (!grow_heap(ext / 4, bp))
						r.st = ST_OOM;
					else
						found = 1'b1;
				end
				if (found) begin
					place_block(bp, asz);
					rover = blk_next(bp);
					r.addr = bp[17:0];
				end
			end
		end else begin
			bp = addr;
			s = 32'(blk_size(bp));
			heap_wr(bp - 4, s);
			heap_wr(blk_ftr(bp), s);
			m = coalesce(bp);
			r.addr = m[17:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [17:0] exp_v, logic [17:0] got_v);
		$display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
		errors++;
	endtask

	task automatic send_item(logic op, logic [18:0] req, logic [17:0] addr,
			bit typed = 0, logic [17:0] e_addr = 0, logic [1:0] e_st = 0);
		res_t r;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_bytes <= req;
		block_addr <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_op(op, req, addr);
		if (op == OP_ALLOC && r.st == ST_OK)
			live.push_back(r.addr);
		if (typed) begin
			r.addr = e_addr;
			r.st = e_st;
		end
		pending.push_back(r);
	endtask

	task automatic drain_and_configure(logic [18:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		chunk = value;
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int r, s, k;
		logic [18:0] req;
		r = $urandom_range(99);
		if (r >= 50 && r < 95 && live.size() != 0) begin
			k = $urandom_range(live.size() - 1);
			send_item(OP_FREE, 19'd0, live[k]);
			live.delete(k);
		end else if (r >= 95) begin
			send_item(OP_FREE, 19'($urandom), 18'($urandom));
		end else begin
			s = $urandom_range(99);
			if (s < 70)
				req = 19'($urandom_range(128, 1));
			else if (s < 90)
				req = 19'($urandom_range(2048, 129));
			else if (s < 96)
				req = 19'($urandom_range(40000, 2049));
			else if (s < 98)
				req = $urandom_range(1) ? 19'd262144 : 19'($urandom);
			else
				req = 19'd0;
			send_item(OP_ALLOC, req, 18'($urandom));
		end
	endtask

	// receive side: random stalls, compare with oldest expectation
	initial begin
		res_t e;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending.size() == 0) begin
					report_mismatch("unexpected transaction", 18'd0, result_addr);
				end else begin
					e = pending.pop_front();
					if (result_addr !== e.addr)
						report_mismatch("result_addr", e.addr, result_addr);
					if (status !== e.st)
						report_mismatch("status", 18'(e.st), 18'(status));
				end
			end
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	initial begin
		row_t dir [$];
		logic [18:0] cfgs [6];
		int n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		opcode <= OP_ALLOC;
		request_bytes <= '0;
		block_addr <= '0;
		heap_init();
		snd_idle = 27;
		rcv_idle = 87;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		dir = '{
			'{OP_ALLOC, 19'd1, 18'd0, 1, 18'd16, ST_OK},
			'{OP_ALLOC, 19'd8, 18'd0, 1, 18'd32, ST_OK},
			'{OP_ALLOC, 19'd0, 18'd0, 1, 18'd0, ST_ZERO},
			'{OP_ALLOC, 19'd262144, 18'd0, 1, 18'd0, ST_OOM},
			'{OP_ALLOC, 19'h7FFFF, 18'd0, 1, 18'd0, ST_OOM},
			'{OP_FREE, 19'd0, 18'd16, 1, 18'd16, ST_OK},
			'{OP_FREE, 19'd0, 18'd32, 1, 18'd16, ST_OK},
			'{OP_ALLOC, 19'd9, 18'd0, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd100, 18'd0, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd24, 18'd0, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd65536, 18'd0, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd1000, 18'd0, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'd0, 18'd48, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'd0, 18'd16, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'd0, 18'd64, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd40, 18'd0, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd120000, 18'd0, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'h7FFFF, 18'd0, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'd0, 18'h3FFFF, 0, 18'd0, ST_OK},
			'{OP_FREE, 19'd0, 18'd3, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd16, 18'h3FFFF, 0, 18'd0, ST_OK},
			'{OP_ALLOC, 19'd17, 18'd0, 0, 18'd0, ST_OK}
		};
		@(posedge clk);
		foreach (dir[i])
			send_item(dir[i].op, dir[i].req, dir[i].addr,
				dir[i].typed, dir[i].e_addr, dir[i].e_st);
		live.delete();

		cfgs = '{19'd65536, 19'd8, 19'd262144, 19'd13, 19'd0, 19'd4096};
		foreach (cfgs[p]) begin
			drain_and_configure(cfgs[p]);
			if (p >= 4) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (p >= 2) begin
				snd_idle = 87;
				rcv_idle = 27;
			end
			n = 0;
			while (n < 330) begin
				random_item();
				n++;
			end
		end

		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("next_fit_heap_allocator_unit test passed");
		else
			$display("next_fit_heap_allocator_unit test failed");
		$finish;
	end

endmodule

/* next_fit_heap_allocator_unit.f */
sv/nfha_pkg.sv
sv/nfha_store.sv
sv/next_fit_heap_allocator_unit.sv
bench/tb_top.sv
